// ----- src/neighbor_table_component_counter_top_assert.svh -----
// Assertion macros used by the checker of this block.
// Both sample on the rising edge of clk_i and are disabled while rst_ni is low.
`ifndef NEIGHBOR_TABLE_COMPONENT_COUNTER_TOP_ASSERT_SVH
`define NEIGHBOR_TABLE_COMPONENT_COUNTER_TOP_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define NTCC_ASSERT_SAME(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define NTCC_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/ntcc_pkg.sv -----
`default_nettype none

package ntcc_pkg;

  localparam int unsigned MaxNodesDefault = 64;
  localparam int unsigned NodeIdWidth     = 6;
  localparam int unsigned CountWidth      = 7;
  localparam int unsigned TallyWidth      = 32;
  localparam int unsigned ApbAddrWidth    = 3;
  localparam int unsigned ApbDataWidth    = 32;

  localparam logic [CountWidth-1:0]  NodeCountReset  = 7'd64;
  localparam logic [NodeIdWidth-1:0] SourceNodeReset = 6'd0;

  typedef enum logic [1:0] {
    MODE_HELLO_RX = 2'd0,
    MODE_HELLO_TX = 2'd1,
    MODE_REPORT   = 2'd2
  } mode_e;

  typedef struct packed {
    logic [1:0]             mode;
    logic [NodeIdWidth-1:0] receiver_node;
    logic [NodeIdWidth-1:0] sender_node;
  } req_t;

  typedef struct packed {
    logic [CountWidth-1:0] neighbor_count;
    logic [CountWidth-1:0] component_count;
    logic [TallyWidth-1:0] received_count;
    logic [TallyWidth-1:0] sent_count;
  } rsp_t;

  // Controller to datapath
  typedef struct packed {
    logic hello_rx;
    logic hello_tx;
    logic begin_report;
    logic rd_src;
    logic ld_row;
    logic scan_nb;
    logic start_search;
    logic skip_node;
    logic end_search;
    logic pop;
    logic rd_node;
    logic scan_edge;
    logic finish;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic n_zero;
    logic scan_last;
    logic node_done;
    logic node_visited;
    logic stack_empty;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

// ----- src/neighbor_table_component_counter_top.sv -----
// Hello received / hello sent requests: one per cycle, outside of a report.
// Period-end report with n = min(node_count, MaxNodes, 64) nodes in use: the
// matrix is read row by row and each row is scanned one column a cycle;
// when n is zero the reads and scans are skipped.
// The result waits in an output register; hello requests are taken meanwhile.
// Reset (rst_ni low, asynchronous) empties the matrix and counters at once.
`default_nettype none

module neighbor_table_component_counter_top #(
  parameter int unsigned MaxNodes = ntcc_pkg::MaxNodesDefault
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  // configuration port
  input  wire logic                                 psel,
  input  wire logic                                 penable,
  input  wire logic                                 pwrite,
  input  wire logic [ntcc_pkg::ApbAddrWidth-1:0]    paddr,
  input  wire logic [ntcc_pkg::ApbDataWidth-1:0]    pwdata,
  output logic      [ntcc_pkg::ApbDataWidth-1:0]    prdata,
  output logic                                      pready,
  // request channel
  input  wire logic                                 in_valid_i,
  output logic                                      in_stall_o,
  input  wire ntcc_pkg::req_t                       in_req_i,
  // result channel
  output logic                                      out_valid_o,
  input  wire logic                                 out_stall_i,
  output ntcc_pkg::rsp_t                            out_rsp_o
);

  localparam int unsigned DW = ntcc_pkg::ApbDataWidth;
  localparam int unsigned KW = ntcc_pkg::CountWidth;
  localparam int unsigned IW = ntcc_pkg::NodeIdWidth;

  // Register index, taken from paddr[2] (registers sit at 4-byte spacing)
  localparam logic REG_NODE_COUNT  = 1'b0;
  localparam logic REG_SOURCE_NODE = 1'b1;

  logic [KW-1:0]  node_count_q;
  logic [IW-1:0]  source_node_q;
  logic           cfg_write;
  ntcc_pkg::cmd_t cmd;
  ntcc_pkg::sts_t sts;

  // The port never waits: every access completes in its access cycle.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  // Configuration registers. The user must write only while no request is in
  // flight, so the report logic sees them steady; the block does not check.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_count_q  <= ntcc_pkg::NodeCountReset;
      source_node_q <= ntcc_pkg::SourceNodeReset;
    end else if (cfg_write) begin
      unique case (paddr[2])
        REG_NODE_COUNT:  node_count_q  <= pwdata[KW-1:0];
        REG_SOURCE_NODE: source_node_q <= pwdata[IW-1:0];
        default: ;
      endcase
    end
  end

  // Read back the addressed register, zero-extended to the bus width.
  always_comb begin
    unique case (paddr[2])
      REG_NODE_COUNT:  prdata = DW'(node_count_q);
      REG_SOURCE_NODE: prdata = DW'(source_node_q);
      default:         prdata = '0;
    endcase
  end

  // Sequencer: takes hello requests in idle, walks the report otherwise.
  ntcc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_mode_i  (in_req_i.mode),
    .sts_i      (sts),
    .cmd_o      (cmd),
    .in_stall_o (in_stall_o)
  );

  // Matrix, search stack, counters and the result register.
  ntcc_dp #(
    .MaxNodes (MaxNodes)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .req_i         (in_req_i),
    .node_count_i  (node_count_q),
    .source_node_i (source_node_q),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_rsp_o     (out_rsp_o)
  );

endmodule

`default_nettype wire

// ----- src/ntcc_ctrl.sv -----
`default_nettype none

module ntcc_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  input  wire logic [1:0]    in_mode_i,
  input  wire ntcc_pkg::sts_t sts_i,
  output ntcc_pkg::cmd_t     cmd_o,
  output logic               in_stall_o
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_NB_RD,
    S_NB_LD,
    S_NB_SCAN,
    S_NODE,
    S_POP,
    S_POP_RD,
    S_ROW_LD,
    S_EDGE_SCAN,
    S_DONE
  } state_e;

  state_e state_q, state_d;

  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          case (ntcc_pkg::mode_e'(in_mode_i))
            ntcc_pkg::MODE_HELLO_RX: cmd_o.hello_rx = 1'b1;
            ntcc_pkg::MODE_HELLO_TX: cmd_o.hello_tx = 1'b1;
            ntcc_pkg::MODE_REPORT: begin
              cmd_o.begin_report = 1'b1;
              state_d            = S_NB_RD;
            end
            default: ;
          endcase
        end
      end
      S_NB_RD: begin
        if (sts_i.n_zero) begin
          state_d = S_DONE;
        end else begin
          cmd_o.rd_src = 1'b1;
          state_d      = S_NB_LD;
        end
      end
      S_NB_LD: begin
        cmd_o.ld_row = 1'b1;
        state_d      = S_NB_SCAN;
      end
      S_NB_SCAN: begin
        cmd_o.scan_nb = 1'b1;
        if (sts_i.scan_last) state_d = S_NODE;
      end
      S_NODE: begin
        if (sts_i.node_done) begin
          state_d = S_DONE;
        end else if (sts_i.node_visited) begin
          cmd_o.skip_node = 1'b1;
        end else begin
          cmd_o.start_search = 1'b1;
          state_d            = S_POP;
        end
      end
      S_POP: begin
        if (sts_i.stack_empty) begin
          cmd_o.end_search = 1'b1;
          state_d          = S_NODE;
        end else begin
          cmd_o.pop = 1'b1;
          state_d   = S_POP_RD;
        end
      end
      S_POP_RD: begin
        cmd_o.rd_node = 1'b1;
        state_d       = S_ROW_LD;
      end
      S_ROW_LD: begin
        cmd_o.ld_row = 1'b1;
        state_d      = S_EDGE_SCAN;
      end
      S_EDGE_SCAN: begin
        cmd_o.scan_edge = 1'b1;
        if (sts_i.scan_last) state_d = S_POP;
      end
      S_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

// ----- src/ntcc_dp.sv -----
`default_nettype none

module ntcc_dp #(
  parameter int unsigned MaxNodes = ntcc_pkg::MaxNodesDefault
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire ntcc_pkg::cmd_t                      cmd_i,
  output ntcc_pkg::sts_t                           sts_o,
  input  wire ntcc_pkg::req_t                      req_i,
  input  wire logic [ntcc_pkg::CountWidth-1:0]     node_count_i,
  input  wire logic [ntcc_pkg::NodeIdWidth-1:0]    source_node_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_stall_i,
  output ntcc_pkg::rsp_t                           out_rsp_o
);

  localparam int unsigned Rows = (MaxNodes < 64) ? MaxNodes : 64;
  localparam int unsigned AW   = $clog2(Rows);
  localparam int unsigned CW   = $clog2(Rows + 1);
  localparam int unsigned KW   = ntcc_pkg::CountWidth;
  localparam int unsigned TW   = ntcc_pkg::TallyWidth;

  // Adjacency matrix and search stack
  logic [Rows-1:0] adj_mem_q   [Rows];
  logic [AW-1:0]   stack_mem_q [Rows];

  logic [Rows-1:0] row_vld_q;
  logic [Rows-1:0] visited_q;
  logic [Rows-1:0] adj_rd_q;
  logic            adj_vld_q;
  logic [Rows-1:0] row_q;
  logic [AW-1:0]   u_q;
  logic [AW-1:0]   stack_rd_q;
  logic [CW-1:0]   sp_q, c_q, i_q, nb_q, comps_q;
  logic [1:0]      edges_q;
  logic [TW-1:0]   rx_q, tx_q;
  logic            out_valid_q;
  ntcc_pkg::rsp_t  rsp_q;

  logic [CW-1:0]   n;
  logic [AW-1:0]   rcv_a, snd_a, c_a, i_a, adj_rd_addr, push_node;
  logic [Rows-1:0] snd_onehot;
  logic            hello_in_range, src_ok, push_en;

  always_comb begin
    n = (node_count_i > KW'(Rows)) ? CW'(Rows) : node_count_i[CW-1:0];
  end

  assign rcv_a  = req_i.receiver_node[AW-1:0];
  assign snd_a  = req_i.sender_node[AW-1:0];
  assign c_a    = c_q[AW-1:0];
  assign i_a    = i_q[AW-1:0];
  assign src_ok = ({1'b0, source_node_i} < KW'(n));

  assign hello_in_range = ({1'b0, req_i.receiver_node} < KW'(Rows)) &&
                          ({1'b0, req_i.sender_node} < KW'(Rows));

  always_comb begin
    snd_onehot        = '0;
    snd_onehot[snd_a] = 1'b1;
  end

  assign adj_rd_addr = cmd_i.rd_node ? stack_rd_q : source_node_i[AW-1:0];

  // Push the search root, or an unvisited column set in the scanned row
  assign push_en   = cmd_i.start_search || (cmd_i.scan_edge && row_q[0] && !visited_q[c_a]);
  assign push_node = cmd_i.start_search ? i_a : c_a;

  always_ff @(posedge clk_i) begin
    if (cmd_i.hello_rx && hello_in_range) begin
      if (row_vld_q[rcv_a]) begin
        adj_mem_q[rcv_a][snd_a] <= 1'b1;
      end else begin
        adj_mem_q[rcv_a] <= snd_onehot;
      end
    end
    if (cmd_i.rd_src || cmd_i.rd_node) begin
      adj_rd_q  <= adj_mem_q[adj_rd_addr];
      adj_vld_q <= row_vld_q[adj_rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_en) begin
      stack_mem_q[sp_q[AW-1:0]] <= push_node;
    end
    if (cmd_i.pop) begin
      stack_rd_q <= stack_mem_q[sp_q[AW-1:0] - AW'(1)];
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_row) begin
      row_q <= adj_rd_q & {Rows{adj_vld_q}};
    end else if (cmd_i.scan_nb || cmd_i.scan_edge) begin
      row_q <= row_q >> 1;
    end
    if (cmd_i.rd_node) begin
      u_q <= stack_rd_q;
    end
    if (cmd_i.finish) begin
      rsp_q.neighbor_count  <= KW'(nb_q);
      rsp_q.component_count <= KW'(comps_q);
      rsp_q.received_count  <= rx_q;
      rsp_q.sent_count      <= tx_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_vld_q   <= '0;
      visited_q   <= '0;
      sp_q        <= '0;
      c_q         <= '0;
      i_q         <= '0;
      nb_q        <= '0;
      comps_q     <= '0;
      edges_q     <= '0;
      rx_q        <= '0;
      tx_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.hello_rx) begin
        if (hello_in_range) row_vld_q[rcv_a] <= 1'b1;
        if (rx_q != '1) rx_q <= rx_q + TW'(1);
      end
      if (cmd_i.hello_tx && tx_q != '1) begin
        tx_q <= tx_q + TW'(1);
      end
      if (cmd_i.begin_report) begin
        visited_q <= '0;
        sp_q      <= '0;
        i_q       <= '0;
        nb_q      <= '0;
        comps_q   <= '0;
      end
      if (cmd_i.ld_row) begin
        c_q <= '0;
      end
      if (cmd_i.scan_nb) begin
        c_q <= c_q + CW'(1);
        if (row_q[0] && src_ok && (KW'(c_q) != {1'b0, source_node_i})) begin
          nb_q <= nb_q + CW'(1);
        end
      end
      if (cmd_i.scan_edge) begin
        c_q <= c_q + CW'(1);
        if (row_q[0] && (c_q != CW'(u_q)) && (edges_q != 2'd2)) begin
          edges_q <= edges_q + 2'd1;
        end
      end
      if (push_en) begin
        visited_q[push_node] <= 1'b1;
        sp_q                 <= sp_q + CW'(1);
      end
      if (cmd_i.start_search) begin
        edges_q <= '0;
      end
      if (cmd_i.pop) begin
        sp_q <= sp_q - CW'(1);
      end
      if (cmd_i.skip_node) begin
        i_q <= i_q + CW'(1);
      end
      if (cmd_i.end_search) begin
        i_q <= i_q + CW'(1);
        if (edges_q == 2'd2) comps_q <= comps_q + CW'(1);
      end
      if (cmd_i.finish) begin
        row_vld_q   <= '0;
        rx_q        <= '0;
        tx_q        <= '0;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign sts_o.n_zero       = (n == '0);
  assign sts_o.scan_last    = (c_q == n - CW'(1));
  assign sts_o.node_done    = (i_q == n);
  assign sts_o.node_visited = visited_q[i_a];
  assign sts_o.stack_empty  = (sp_q == '0);
  assign sts_o.out_free     = !out_valid_q || !out_stall_i;

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = rsp_q;

endmodule

`default_nettype wire

// ----- src/ntcc_checker.sv -----
`default_nettype none
`include "neighbor_table_component_counter_top_assert.svh"

module ntcc_checker (
  input wire logic           clk_i,
  input wire logic           rst_ni,
  input wire logic           in_valid_i,
  input wire logic           in_stall_o,
  input wire ntcc_pkg::req_t in_req_i,
  input wire logic           out_valid_o,
  input wire logic           out_stall_i,
  input wire ntcc_pkg::rsp_t out_rsp_o
);

  logic in_take, take_report, take_hello, out_held, counts_ok;

  assign in_take     = in_valid_i && !in_stall_o;
  assign take_report = in_take && (in_req_i.mode == ntcc_pkg::MODE_REPORT);
  assign take_hello  = in_take && (in_req_i.mode != ntcc_pkg::MODE_REPORT);
  assign out_held    = out_valid_o && out_stall_i;
  assign counts_ok   = (out_rsp_o.neighbor_count < 7'd64) &&
                       (out_rsp_o.component_count <= 7'd64);

  `NTCC_ASSERT_NEXT(a_out_hold, out_held, out_valid_o && $stable(out_rsp_o), "stalled result lost")
  `NTCC_ASSERT_NEXT(a_report_busy, take_report, in_stall_o, "report did not stall input")
  `NTCC_ASSERT_NEXT(a_hello_single, take_hello, !in_stall_o, "hello took over a cycle")
  `NTCC_ASSERT_SAME(a_result_from_report, $rose(out_valid_o), $past(in_stall_o), "stray result")
  `NTCC_ASSERT_SAME(a_counts_range, out_valid_o, counts_ok, "reported node counts out of range")

endmodule

bind neighbor_table_component_counter_top ntcc_checker u_ntcc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_req_i    (in_req_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_rsp_o   (out_rsp_o)
);

`default_nettype wire
